>>> design/svm_pkg.sv
`default_nettype none

package svm_pkg;

    // input word kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic write_word;
        logic start_voice;
        logic clear_sum;
        logic scan;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } status_t;

    localparam logic [14:0] LIMIT_RESET = 15'd28000;
    localparam logic [16:0] MAX_LENGTH  = 17'd65536;

endpackage

`default_nettype wire

>>> design/svm_ctrl.sv
`default_nettype none

module svm_ctrl #(
    parameter int VOICES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        kind,
    input  wire svm_pkg::status_t  status,
    output svm_pkg::cmd_t          cmd,
    output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] scan_idx
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST = VW'(VOICES - 1);

    svm_pkg::state_t state_reg, state_next;
    logic [VW-1:0]   count_reg, count_next;

    // state and voice counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svm_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign scan_idx = count_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            svm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (svm_pkg::kind_t'(kind))
                        svm_pkg::KIND_WRITE: cmd.write_word  = 1'b1;
                        svm_pkg::KIND_START: cmd.start_voice = 1'b1;
                        svm_pkg::KIND_TICK:
                        begin
                            cmd.clear_sum = 1'b1;
                            count_next    = '0;
                            state_next    = svm_pkg::ST_SCAN;
                        end
                        default: ; // unused kind: dropped
                    endcase
                end
            end
            svm_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (count_reg == LAST)
                    state_next = svm_pkg::ST_DRAIN;
                else
                    count_next = count_reg + VW'(1);
            end
            svm_pkg::ST_DRAIN:
            begin
                // last voice's sample is summed this cycle
                state_next = svm_pkg::ST_EMIT;
            end
            svm_pkg::ST_EMIT:
            begin
                if (!status.out_full)
                begin
                    cmd.emit   = 1'b1;
                    state_next = svm_pkg::ST_IDLE;
                end
            end
            default: state_next = svm_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> design/svm_datapath.sv
`default_nettype none

module svm_datapath #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire svm_pkg::cmd_t      cmd,
    input  wire logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] scan_idx,
    output svm_pkg::status_t        status,
    input  wire logic [15:0]        address,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [3:0]         voice_index,
    input  wire logic [16:0]        sample_count,
    input  wire logic               loop_enable,
    input  wire logic               cfg_write_enable,
    input  wire logic [14:0]        cfg_write_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      mixed_sample
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_WORDS);
    localparam int SW = (AW > 17) ? AW : 17;

    // sample store, no reset
    logic signed [15:0] mem [SAMPLE_WORDS];
    logic signed [15:0] rdata_reg;

    // voice table
    logic [VOICES-1:0] active_reg;
    logic [VOICES-1:0] looping_reg;
    logic [15:0]       base_reg   [VOICES];
    logic [16:0]       length_reg [VOICES];
    logic [15:0]       pos_reg    [VOICES];

    logic [14:0]        limit_reg;
    logic               pend_reg;
    logic signed [15:0] sum_reg, sum_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] out_reg;

    // start decode
    logic [7:0]    vi_wide;
    logic [VW-1:0] vi;
    logic          vi_ok;
    logic [16:0]   len_sat;

    assign vi_wide = 8'(voice_index);
    assign vi      = vi_wide[VW-1:0];
    assign vi_ok   = (32'(voice_index) < VOICES);
    assign len_sat = (sample_count > svm_pkg::MAX_LENGTH) ? svm_pkg::MAX_LENGTH
                                                          : sample_count;

    // scan: fetch address and next position
    logic [SW-1:0] fetch_wide;
    logic [SW-1:0] wr_wide;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [16:0]   pos_inc;
    logic          scan_hit;
    logic          at_end;

    assign fetch_wide = SW'(base_reg[scan_idx]) + SW'(pos_reg[scan_idx]);
    assign rd_addr    = fetch_wide[AW-1:0];
    assign wr_wide    = SW'(address);
    assign wr_addr    = wr_wide[AW-1:0];
    assign pos_inc    = {1'b0, pos_reg[scan_idx]} + 17'd1;
    assign at_end     = (pos_inc >= length_reg[scan_idx]);
    assign scan_hit   = cmd.scan && active_reg[scan_idx];

    // memory ports
    always_ff @(posedge clk)
    begin
        if (cmd.write_word)
            mem[wr_addr] <= sample_value;
        if (scan_hit)
            rdata_reg <= mem[rd_addr];
    end

    // voice flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            looping_reg <= '0;
        end
        else if (cmd.start_voice && vi_ok)
        begin
            active_reg[vi]  <= (len_sat != 17'd0);
            looping_reg[vi] <= loop_enable;
        end
        else if (scan_hit && at_end && !looping_reg[scan_idx])
        begin
            active_reg[scan_idx] <= 1'b0;
        end
    end

    // voice setup and position
    always_ff @(posedge clk)
    begin
        if (cmd.start_voice && vi_ok)
        begin
            base_reg[vi]   <= address;
            length_reg[vi] <= len_sat;
            pos_reg[vi]    <= '0;
        end
        else if (scan_hit)
        begin
            pos_reg[scan_idx] <= at_end ? 16'd0 : pos_inc[15:0];
        end
    end

    // add and clamp
    logic signed [17:0] lim_pos, lim_neg, acc_wide;

    assign lim_pos  = $signed({3'b000, limit_reg});
    assign lim_neg  = -lim_pos;
    assign acc_wide = 18'(sum_reg) + 18'(rdata_reg);

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.clear_sum)
            sum_next = '0;
        else if (pend_reg)
        begin
            if (acc_wide > lim_pos)
                sum_next = lim_pos[15:0];
            else if (acc_wide < lim_neg)
                sum_next = lim_neg[15:0];
            else
                sum_next = acc_wide[15:0];
        end
    end

    // output register handshake
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= svm_pkg::LIMIT_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
                limit_reg <= cfg_write_data;
            pend_reg      <= scan_hit;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.emit)
            out_reg <= sum_reg;
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign mixed_sample    = out_reg;

endmodule

`default_nettype wire

>>> design/saturating_voice_mixer.sv
`default_nettype none

// Mixer of up to VOICES PCM voices over one shared store of SAMPLE_WORDS
// signed 16-bit words (SAMPLE_WORDS a power of two; addresses wrap in it).
// Write and start words are applied in idle. A tick word is accepted, then
// each voice slot in turn reads that voice's sample through the store's
// single read port; the last sample is then summed and the output register
// loaded once it can take a result; the next word is taken when the
// controller is back in idle, also while a result still waits at the output.
// The running mix is clamped to +/- the amplitude limit after each voice;
// the limit is written through cfg_write_enable / cfg_write_data and resets
// to 28000. Store words are undefined until written.
module saturating_voice_mixer #(
    parameter int VOICES       = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        address,
    input  wire logic signed [15:0] sample_value,
    input  wire logic [3:0]         voice_index,
    input  wire logic [16:0]        sample_count,
    input  wire logic               loop_enable,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      mixed_sample,
    input  wire logic               cfg_write_enable,
    input  wire logic [14:0]        cfg_write_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    svm_pkg::cmd_t    cmd;
    svm_pkg::status_t status;
    logic [VW-1:0]    scan_idx;

    // sequencer
    svm_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    // store, voice table, accumulator
    svm_datapath #(
        .VOICES       (VOICES),
        .SAMPLE_WORDS (SAMPLE_WORDS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .scan_idx         (scan_idx),
        .status           (status),
        .address          (address),
        .sample_value     (sample_value),
        .voice_index      (voice_index),
        .sample_count     (sample_count),
        .loop_enable      (loop_enable),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mixed_sample     (mixed_sample)
    );

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int         VOICES      = 16;
    localparam int         STORE_WORDS = 65536;
    localparam int         WORD_GOAL   = 1450;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         LONG_HOLD   = 400;
    localparam int         SETTLE      = VOICES + 8;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // mix predictor: own copy of the store, the voice slots and the limit
    class mix_scoreboard;
        logic signed [15:0] words [STORE_WORDS];
        bit                 written [STORE_WORDS];
        bit                 active [VOICES];
        bit                 looping [VOICES];
        logic [15:0]        base [VOICES];
        logic [16:0]        length [VOICES];
        logic [15:0]        position [VOICES];
        logic [14:0]        limit;
        logic signed [15:0] expected_mix [$];
        int                 errors;
        int                 ticks;
        int                 writes;
        int                 starts;
        int                 clamps;

        function new();
            limit  = svm_pkg::LIMIT_RESET;
            errors = 0;
            ticks  = 0;
            writes = 0;
            starts = 0;
            clamps = 0;
            for (int i = 0; i < VOICES; i++)
            begin
                active[i]   = 1'b0;
                looping[i]  = 1'b0;
                base[i]     = '0;
                length[i]   = '0;
                position[i] = '0;
            end
        endfunction

        function int pending();
            return expected_mix.size();
        endfunction

        // apply one accepted word; a tick queues the mix it must produce
        function void note_input(input logic [1:0] kind_in, input logic [15:0] addr,
                                 input logic signed [15:0] value, input logic [3:0] vi,
                                 input logic [16:0] count, input logic lp);
            logic [16:0] len;
            logic [16:0] next;
            logic [15:0] a;
            int          sum;
            int          lim;
            if (kind_in == svm_pkg::KIND_WRITE)
            begin
                words[addr]   = value;
                written[addr] = 1'b1;
                writes++;
            end
            else if (kind_in == svm_pkg::KIND_START)
            begin
                len          = (count > svm_pkg::MAX_LENGTH) ? svm_pkg::MAX_LENGTH : count;
                base[vi]     = addr;
                length[vi]   = len;
                position[vi] = '0;
                looping[vi]  = lp;
                active[vi]   = (len != 0);
                starts++;
            end
            else if (kind_in == svm_pkg::KIND_TICK)
            begin
                lim = int'(limit);
                sum = 0;
                for (int i = 0; i < VOICES; i++)
                begin
                    if (active[i])
                    begin
                        a   = base[i] + position[i];
                        sum = sum + int'(words[a]);
                        if (sum > lim)
                        begin
                            sum = lim;
                            clamps++;
                        end
                        if (sum < -lim)
                        begin
                            sum = -lim;
                            clamps++;
                        end
                        // last sample of a one-shot voice is played, then it stops
                        next = {1'b0, position[i]} + 17'd1;
                        if (next >= length[i])
                        begin
                            next = '0;
                            if (!looping[i])
                                active[i] = 1'b0;
                        end
                        position[i] = next[15:0];
                    end
                end
                expected_mix.push_back(sum[15:0]);
                ticks++;
            end
        endfunction

        function void check_result(input logic signed [15:0] actual);
            logic signed [15:0] want;
            if (expected_mix.size() == 0)
            begin
                $error("mixed_sample: no result expected, actual %0d", actual);
                errors++;
            end
            else
            begin
                want = expected_mix.pop_front();
                if (actual !== want)
                begin
                    $error("mixed_sample: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n            = 1'b0;
    logic               in_valid         = 1'b0;
    logic               in_ready;
    logic [1:0]         kind             = svm_pkg::KIND_WRITE;
    logic [15:0]        address          = '0;
    logic signed [15:0] sample_value     = '0;
    logic [3:0]         voice_index      = '0;
    logic [16:0]        sample_count     = '0;
    logic               loop_enable      = 1'b0;
    logic               out_valid;
    logic               out_ready        = 1'b0;
    logic signed [15:0] mixed_sample;
    logic               cfg_write_enable = 1'b0;
    logic [14:0]        cfg_write_data   = svm_pkg::LIMIT_RESET;

    mix_scoreboard sb;
    bit            offering       = 1'b0;
    bit            hold_req       = 1'b0;
    int            burst_left     = 0;
    int            gap_max        = 8;
    int            words_sent     = 0;
    int            limit_settings = 1;
    int            cycle_count    = 0;

    saturating_voice_mixer #(
        .VOICES       (VOICES),
        .SAMPLE_WORDS (STORE_WORDS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .address          (address),
        .sample_value     (sample_value),
        .voice_index      (voice_index),
        .sample_count     (sample_count),
        .loop_enable      (loop_enable),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mixed_sample     (mixed_sample),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // output side: stall patterns, plus one long hold on request
    initial
    begin : receiver
        int mode;
        int span;
        int hold;
        int beat;
        mode = 0;
        span = 0;
        hold = 0;
        beat = 0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((beat % 7) < 4);
                endcase
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(mixed_sample);
    end

    task automatic lower_valid();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // offer one word, wait for the handshake, then pace the next burst
    task automatic send_word(input logic [1:0] k, input logic [15:0] addr,
                             input logic signed [15:0] value, input logic [3:0] vi,
                             input logic [16:0] count, input logic lp);
        in_valid     <= 1'b1;
        kind         <= k;
        address      <= addr;
        sample_value <= value;
        voice_index  <= vi;
        sample_count <= count;
        loop_enable  <= lp;
        offering = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(k, addr, value, vi, count, lp);
        if (k != KIND_UNUSED)
            words_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 24);
            if (gap_max > 0)
            begin
                lower_valid();
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
    endtask

    task automatic pause_until_drained();
        lower_valid();
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic settle_and_set_limit(input logic [14:0] value);
        pause_until_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        sb.limit = value;
        limit_settings++;
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'(int'($urandom_range(0, 600)) - 300);
            3:       return 16'sh0000;
            4:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // tick word; any word an active voice is about to read gets written first
    task automatic send_tick();
        logic [15:0] a;
        for (int i = 0; i < VOICES; i++)
        begin
            if (sb.active[i])
            begin
                a = sb.base[i] + sb.position[i];
                if (!sb.written[a])
                    send_word(svm_pkg::KIND_WRITE, a, random_sample(), 4'($urandom),
                              17'($urandom), 1'($urandom));
            end
        end
        send_word(svm_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 4'($urandom),
                  17'($urandom), 1'($urandom));
    endtask

    // well-formed clip: load a block, start voices inside it, play ticks
    task automatic play_clip();
        int          len;
        int          off;
        int          cnt;
        int          n;
        logic [15:0] clip_base;
        len = $urandom_range(1, 20);
        if ($urandom_range(0, 3) == 0)
            clip_base = 16'hFFFF - 16'($urandom_range(0, 10));
        else
            clip_base = 16'($urandom);
        for (int k = 0; k < len; k++)
            send_word(svm_pkg::KIND_WRITE, clip_base + 16'(k), random_sample(),
                      4'($urandom), 17'($urandom), 1'($urandom));
        n = $urandom_range(1, 3);
        for (int s = 0; s < n; s++)
        begin
            off = $urandom_range(0, len - 1);
            cnt = $urandom_range(1, len - off);
            if ($urandom_range(0, 15) == 0)
                cnt = $urandom_range(65536, 131071);
            send_word(svm_pkg::KIND_START, clip_base + 16'(off), 16'($urandom),
                      4'($urandom), 17'(cnt), 1'($urandom));
        end
        n = $urandom_range(1, 2 * len + 2);
        for (int t = 0; t < n; t++)
            send_tick();
    endtask

    // loose words: random kinds and fields, zero and overlong lengths
    task automatic send_noise();
        logic [16:0] cnt;
        case ($urandom_range(0, 4))
            0:
                send_word(svm_pkg::KIND_WRITE, 16'($urandom), random_sample(),
                          4'($urandom), 17'($urandom), 1'($urandom));
            1:
            begin
                case ($urandom_range(0, 5))
                    0:       cnt = '0;
                    1:       cnt = 17'($urandom);
                    2:       cnt = svm_pkg::MAX_LENGTH;
                    default: cnt = 17'($urandom_range(1, 40));
                endcase
                send_word(svm_pkg::KIND_START, 16'($urandom), 16'($urandom),
                          4'($urandom), cnt, 1'($urandom));
            end
            3:
                send_word(KIND_UNUSED, 16'($urandom), 16'($urandom), 4'($urandom),
                          17'($urandom), 1'($urandom));
            default:
                send_tick();
        endcase
    endtask

    initial
    begin : stimulus
        logic [14:0] lim;
        int          mid;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: silence, store wrap, clamps both ways, one-shot voice
        send_tick();
        send_word(svm_pkg::KIND_WRITE, 16'h0000, 16'sh8000, 4'd0, 17'd0, 1'b0);
        send_word(svm_pkg::KIND_WRITE, 16'hFFFF, 16'sh7FFF, 4'd0, 17'd0, 1'b0);
        send_word(svm_pkg::KIND_WRITE, 16'h0001, 16'sh7FFF, 4'd0, 17'd0, 1'b0);
        send_word(svm_pkg::KIND_WRITE, 16'h0002, 16'shFFFF, 4'd0, 17'd0, 1'b0);
        send_word(svm_pkg::KIND_START, 16'hFFFF, 16'sh0000, 4'd0, 17'd2, 1'b1);
        send_word(svm_pkg::KIND_START, 16'h0001, 16'sh0000, 4'd15, 17'd1, 1'b0);
        send_tick();
        send_tick();
        send_tick();
        // zero length, overlong length, unused kind, restart of a live voice
        send_word(svm_pkg::KIND_START, 16'h0000, 16'sh0000, 4'd3, 17'd0, 1'b1);
        send_word(svm_pkg::KIND_START, 16'h0002, 16'sh0000, 4'd5, 17'h1FFFF, 1'b0);
        send_word(KIND_UNUSED, 16'hFFFF, 16'sh7FFF, 4'd15, 17'h1FFFF, 1'b1);
        send_word(svm_pkg::KIND_START, 16'h0001, 16'sh0000, 4'd0, 17'd3, 1'b0);
        send_tick();
        send_tick();
        send_tick();
        // zero limit silences everything
        settle_and_set_limit(15'd0);
        send_word(svm_pkg::KIND_START, 16'hFFFF, 16'sh0000, 4'd7, 17'd2, 1'b1);
        send_tick();
        send_tick();

        // random phases, one limit each
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       lim = 15'h7FFF;
                1:       lim = 15'd1;
                2:       lim = 15'($urandom_range(2, 32766));
                3:       lim = 15'd300;
                default: lim = svm_pkg::LIMIT_RESET;
            endcase
            settle_and_set_limit(lim);
            gap_max = (p == 3) ? 0 : ((p == 1) ? 2 : 8);
            // long output stall while words keep coming
            if (p == 0)
                hold_req = 1'b1;
            mid = (WORD_GOAL * (2 * p + 1)) / 10;
            while (words_sent < (WORD_GOAL * (p + 1)) / 5)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    play_clip();
                if (mid > 0 && words_sent >= mid)
                begin
                    mid = 0;
                    pause_until_drained();
                end
            end
        end

        // drain, then let the block settle
        pause_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("mixed_sample: %0d results never arrived", sb.pending());
            sb.errors++;
        end
        $display("run: %0d words, %0d ticks checked, %0d store writes, %0d voice starts",
                 words_sent, sb.ticks, sb.writes, sb.starts);
        $display("run: %0d clamp events over %0d limit settings",
                 sb.clamps, limit_settings);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
design/svm_pkg.sv
design/svm_ctrl.sv
design/svm_datapath.sv
design/saturating_voice_mixer.sv
sim/tb.sv
